[hdl/nta_pkg.sv]
// Shared types and constants for the note envelope timing analyser.
package nta_pkg;

   localparam int SAMPLE_W = 24;
   localparam int MAG_W    = 23;
   localparam int ADDR_W   = 18;
   localparam int CNT_W    = 19;
   localparam int HOLD_W   = 16;
   localparam int CHAN_W   = 2;
   localparam int SUM_W    = 64;
   localparam int DIVR_W   = 17;
   localparam int CSR_W    = 19;
   localparam int OUT_W    = 80;

   localparam logic [CNT_W-1:0] MAX_SAMPLES = CNT_W'(262144);
   // peak * 10000 < 2^23  <=>  peak < 839
   localparam logic [MAG_W-1:0] SILENT_LIMIT = MAG_W'(839);
   // m * 100000 < 2^23  <=>  m < 84
   localparam logic [MAG_W-1:0] FLOOR_LIMIT  = MAG_W'(84);

   localparam logic [1:0] REG_CHANNELS = 2'd0;
   localparam logic [1:0] REG_HOLD     = 2'd1;
   localparam logic [1:0] REG_NOTE_OFF = 2'd2;

   typedef enum logic [1:0] {
      RD_FIRST = 2'd0,
      RD_REACH = 2'd1,
      RD_TAIL  = 2'd2
   } nta_rd_sel_type;

   typedef struct packed {
      logic           load;
      logic           square;
      logic           accum;
      logic           first_init;
      logic           first_inc;
      logic           reach_init;
      logic           reach_inc;
      nta_rd_sel_type rd_sel;
      logic           div_init;
      logic           div_step;
      logic           root_init;
      logic           root_step;
      logic           tail_init;
      logic           tail_dec;
      logic           emit;
   } nta_cmd_type;

   typedef struct packed {
      logic final_beat;
      logic silent;
      logic first_go;
      logic first_low;
      logic reach_go;
      logic reach_low;
      logic div_last;
      logic root_last;
      logic tail_go;
      logic tail_below;
      logic out_free;
   } nta_stat_type;

endpackage

[hdl/nta_ctrl.sv]
// Sequencer for sample intake and the post-render scans.
module nta_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  nta_pkg::nta_stat_type stat,
   output nta_pkg::nta_cmd_type  cmd
);
   import nta_pkg::*;

   typedef enum logic [11:0] {
      S_IDLE     = 12'b0000_0000_0001,
      S_SQUARE   = 12'b0000_0000_0010,
      S_ACCUM    = 12'b0000_0000_0100,
      S_FIRST_RD = 12'b0000_0000_1000,
      S_FIRST_CK = 12'b0000_0001_0000,
      S_REACH_RD = 12'b0000_0010_0000,
      S_REACH_CK = 12'b0000_0100_0000,
      S_DIV      = 12'b0000_1000_0000,
      S_ROOT     = 12'b0001_0000_0000,
      S_TAIL_RD  = 12'b0010_0000_0000,
      S_TAIL_CK  = 12'b0100_0000_0000,
      S_DONE     = 12'b1000_0000_0000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.rd_sel = RD_FIRST;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_SQUARE;
            end
         end
         S_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = S_ACCUM;
         end
         S_ACCUM: begin
            cmd.accum = 1'b1;
            if (!stat.final_beat) begin
               state_in = S_IDLE;
            end else if (stat.silent) begin
               state_in = S_DONE;
            end else begin
               cmd.first_init = 1'b1;
               state_in       = S_FIRST_RD;
            end
         end
         S_FIRST_RD: begin
            cmd.rd_sel = RD_FIRST;
            if (stat.first_go) begin
               state_in = S_FIRST_CK;
            end else begin
               cmd.reach_init = 1'b1;
               state_in       = S_REACH_RD;
            end
         end
         S_FIRST_CK: begin
            if (stat.first_low) begin
               cmd.first_inc = 1'b1;
               state_in      = S_FIRST_RD;
            end else begin
               cmd.reach_init = 1'b1;
               state_in       = S_REACH_RD;
            end
         end
         S_REACH_RD: begin
            cmd.rd_sel = RD_REACH;
            if (stat.reach_go) begin
               state_in = S_REACH_CK;
            end else begin
               cmd.div_init = 1'b1;
               state_in     = S_DIV;
            end
         end
         S_REACH_CK: begin
            if (stat.reach_low) begin
               cmd.reach_inc = 1'b1;
               state_in      = S_REACH_RD;
            end else begin
               cmd.div_init = 1'b1;
               state_in     = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = S_ROOT;
            end
         end
         S_ROOT: begin
            cmd.root_step = 1'b1;
            if (stat.root_last) begin
               cmd.tail_init = 1'b1;
               state_in      = S_TAIL_RD;
            end
         end
         S_TAIL_RD: begin
            cmd.rd_sel = RD_TAIL;
            if (stat.tail_go) begin
               state_in = S_TAIL_CK;
            end else begin
               state_in = S_DONE;
            end
         end
         S_TAIL_CK: begin
            cmd.rd_sel = RD_TAIL;
            if (stat.tail_below) begin
               cmd.tail_dec = 1'b1;
               state_in     = S_TAIL_RD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      // the root unit is initialised on the last divide step
      if (state_ff == S_DIV && stat.div_last) begin
         cmd.root_init = 1'b1;
      end
   end

endmodule

[hdl/nta_dp.sv]
// Datapath: magnitude store, peak and window sum, divider, square root and scan pointers.
module nta_dp (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [nta_pkg::SAMPLE_W*2-1:0]   req_tdata,
   input  logic                             req_tlast,
   input  logic                             csr_we,
   input  logic [1:0]                       csr_index,
   input  logic [nta_pkg::CSR_W-1:0]        csr_wdata,
   input  nta_pkg::nta_cmd_type             cmd,
   output nta_pkg::nta_stat_type            stat,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [nta_pkg::OUT_W-1:0]        rsp_tdata
);
   import nta_pkg::*;

   logic [MAG_W-1:0] mem [0:(1<<ADDR_W)-1];
   logic [MAG_W-1:0] rd_ff;
   logic [ADDR_W-1:0] rd_addr;

   logic [CHAN_W-1:0] chan_ff;
   logic [HOLD_W-1:0] hold_ff;
   logic [CNT_W-1:0]  noff_ff;

   logic [CNT_W-1:0]  count_ff;
   logic [MAG_W-1:0]  peak_ff;
   logic [ADDR_W-1:0] peak_idx_ff;
   logic [SUM_W-1:0]  sum_ff;
   logic              ovf_ff;

   logic [MAG_W-1:0]  lmag_ff, rmag_ff;
   logic              final_ff, took_ff, win_ff;
   logic [2*MAG_W-1:0] lsq_ff, rsq_ff;

   logic [CNT_W-1:0]  first_ff, reach_ff;
   logic [ADDR_W-1:0] last_ff;

   logic [SUM_W-1:0]  dq_ff;
   logic [DIVR_W-1:0] rem_ff;
   logic [5:0]        dcnt_ff;
   logic [SUM_W-1:0]  x_ff, r_ff, bit_ff;
   logic [4:0]        rcnt_ff;
   logic              rms_ok_ff;
   logic              rprime_ff;

   logic              rsp_valid_ff;
   logic [OUT_W-1:0]  rsp_data_ff;

   function automatic logic [MAG_W-1:0] mag_of(input logic [SAMPLE_W-1:0] v);
      logic [SAMPLE_W-1:0] a;
      a = v[SAMPLE_W-1] ? (~v + SAMPLE_W'(1)) : v;
      return a[SAMPLE_W-1] ? {MAG_W{1'b1}} : a[MAG_W-1:0];
   endfunction

   logic              stereo;
   logic [HOLD_W-1:0] hw;
   logic [CNT_W-1:0]  hw_ext, win_start, idx_off;
   logic              in_win;
   logic [MAG_W-1:0]  m_cur;
   logic [DIVR_W-1:0] divisor;
   logic [DIVR_W:0]   dtrial;
   logic [SUM_W-1:0]  ceil_q, root_sum;
   logic [SUM_W+1:0]  acc_sum;
   logic [MAG_W+6:0]  m50;
   logic [MAG_W+3:0]  m10, p9;
   logic [MAG_W+9:0]  m1000;
   logic [ADDR_W-1:0] attack, tail;
   logic              silent;

   assign stereo  = chan_ff >= CHAN_W'(2);
   assign hw      = (hold_ff == '0) ? HOLD_W'(1) : hold_ff;
   assign hw_ext  = CNT_W'(hw);
   assign win_start = (noff_ff >= hw_ext) ? (noff_ff - hw_ext) : '0;
   assign idx_off = count_ff - win_start;
   assign in_win  = (count_ff >= win_start) && (idx_off < hw_ext);
   assign m_cur   = (lmag_ff > rmag_ff) ? lmag_ff : rmag_ff;
   assign divisor = stereo ? {hw, 1'b0} : {1'b0, hw};
   assign dtrial  = {rem_ff, dq_ff[SUM_W-1]};
   assign ceil_q  = dq_ff + SUM_W'(rem_ff != '0);
   assign root_sum = r_ff + bit_ff;
   assign acc_sum = (SUM_W+2)'(sum_ff) + (SUM_W+2)'(lsq_ff) + (SUM_W+2)'(rsq_ff);
   assign m50     = (MAG_W+7)'(rd_ff) * (MAG_W+7)'(50);
   assign m10     = (MAG_W+4)'(rd_ff) * (MAG_W+4)'(10);
   assign p9      = (MAG_W+4)'(peak_ff) * (MAG_W+4)'(9);
   assign m1000   = (MAG_W+10)'(rd_ff) * (MAG_W+10)'(1000);
   assign silent  = (count_ff == '0) || (peak_ff < SILENT_LIMIT);
   assign attack  = silent ? '0 : ADDR_W'(reach_ff - first_ff);
   assign tail    = (silent || !(CNT_W'(last_ff) > noff_ff)) ? '0
                    : ADDR_W'(CNT_W'(last_ff) - noff_ff);

   always_comb begin
      case (cmd.rd_sel)
         RD_FIRST: rd_addr = first_ff[ADDR_W-1:0];
         RD_REACH: rd_addr = reach_ff[ADDR_W-1:0];
         RD_TAIL:  rd_addr = last_ff;
         default:  rd_addr = first_ff[ADDR_W-1:0];
      endcase
   end

   always_comb begin
      stat.final_beat = final_ff;
      stat.silent     = silent;
      stat.first_go   = first_ff < count_ff;
      stat.first_low  = m50 < (MAG_W+7)'(peak_ff);
      stat.reach_go   = first_ff < count_ff && reach_ff < CNT_W'(peak_idx_ff);
      stat.reach_low  = m10 < p9;
      stat.div_last   = dcnt_ff == 6'd63;
      stat.root_last  = rcnt_ff == 5'd31;
      stat.tail_go    = CNT_W'(last_ff) > noff_ff;
      stat.tail_below = (rd_ff < FLOOR_LIMIT) ||
                        (rms_ok_ff && SUM_W'(m1000) <= r_ff);
      stat.out_free   = !rsp_valid_ff || rsp_tready;
   end

   always_ff @(posedge clock) begin
      rd_ff <= mem[rd_addr];
      if (cmd.square && took_ff) begin
         mem[count_ff[ADDR_W-1:0]] <= m_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_ff <= CHAN_W'(2);
         hold_ff <= HOLD_W'(4800);
         noff_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_CHANNELS: chan_ff <= csr_wdata[CHAN_W-1:0];
            REG_HOLD:     hold_ff <= csr_wdata[HOLD_W-1:0];
            REG_NOTE_OFF: noff_ff <= csr_wdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         peak_ff      <= '0;
         peak_idx_ff  <= '0;
         sum_ff       <= '0;
         ovf_ff       <= 1'b0;
         final_ff     <= 1'b0;
         took_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            final_ff <= req_tlast;
            took_ff  <= count_ff < MAX_SAMPLES;
            win_ff   <= in_win;
            lmag_ff  <= mag_of(req_tdata[SAMPLE_W-1:0]);
            rmag_ff  <= stereo ? mag_of(req_tdata[2*SAMPLE_W-1:SAMPLE_W]) : '0;
            if (count_ff >= MAX_SAMPLES) begin
               ovf_ff <= 1'b1;
            end
         end
         if (cmd.square && took_ff) begin
            lsq_ff   <= (2*MAG_W)'(lmag_ff) * (2*MAG_W)'(lmag_ff);
            rsq_ff   <= (2*MAG_W)'(rmag_ff) * (2*MAG_W)'(rmag_ff);
            count_ff <= count_ff + CNT_W'(1);
            if (m_cur > peak_ff) begin
               peak_ff     <= m_cur;
               peak_idx_ff <= count_ff[ADDR_W-1:0];
            end
         end
         if (cmd.accum && took_ff && win_ff) begin
            sum_ff <= (acc_sum[SUM_W+1:SUM_W] != '0) ? {SUM_W{1'b1}} : acc_sum[SUM_W-1:0];
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
            rsp_data_ff  <= {1'b0, ovf_ff, tail, attack, peak_idx_ff, peak_ff, silent};
            count_ff     <= '0;
            peak_ff      <= '0;
            peak_idx_ff  <= '0;
            sum_ff       <= '0;
            ovf_ff       <= 1'b0;
            final_ff     <= 1'b0;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.first_init) begin
         first_ff <= '0;
      end else if (cmd.first_inc) begin
         first_ff <= first_ff + CNT_W'(1);
      end
      if (cmd.reach_init) begin
         reach_ff <= first_ff;
      end else if (cmd.reach_inc) begin
         reach_ff <= reach_ff + CNT_W'(1);
      end
      if (cmd.tail_init) begin
         last_ff <= ADDR_W'(count_ff - CNT_W'(1));
      end else if (cmd.tail_dec) begin
         last_ff <= last_ff - ADDR_W'(1);
      end
      if (cmd.div_init) begin
         dq_ff   <= sum_ff;
         rem_ff  <= '0;
         dcnt_ff <= '0;
      end else if (cmd.div_step) begin
         dcnt_ff <= dcnt_ff + 6'd1;
         if (dtrial >= {1'b0, divisor}) begin
            rem_ff <= DIVR_W'(dtrial - {1'b0, divisor});
            dq_ff  <= {dq_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_ff <= dtrial[DIVR_W-1:0];
            dq_ff  <= {dq_ff[SUM_W-2:0], 1'b0};
         end
      end
      // prime on the cycle after the last divide step
      if (cmd.root_init) begin
         rms_ok_ff <= 1'b0;
         rcnt_ff   <= '0;
         r_ff      <= '0;
         bit_ff    <= '0;
      end else if (rprime_ff) begin
         rms_ok_ff <= ceil_q != '0;
         x_ff      <= ceil_q - SUM_W'(1);
         r_ff      <= '0;
         bit_ff    <= SUM_W'(1) << 62;
         rcnt_ff   <= '0;
      end else if (cmd.root_step) begin
         rcnt_ff <= rcnt_ff + 5'd1;
         bit_ff  <= bit_ff >> 2;
         if (x_ff >= root_sum) begin
            x_ff <= x_ff - root_sum;
            r_ff <= (r_ff >> 1) + bit_ff;
         end else begin
            r_ff <= r_ff >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rprime_ff <= 1'b0;
      end else begin
         rprime_ff <= cmd.root_init;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[hdl/note_envelope_timing_analyzer_top.sv]
// Each sample beat is taken as magnitude, then square and store, then window accumulate.
// The beat with tlast starts the analysis unless the render is silent: a forward attack
// scan that reads and checks each stored sample in turn (one memory read port), a radix-2
// divide of the window square sum, a square root, and a backward tail scan. One result
// beat follows; the next render may start while it waits to be taken.
module note_envelope_timing_analyzer_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [nta_pkg::SAMPLE_W*2-1:0] req_tdata,  // left_sample, right_sample
   input  logic                           req_tlast,  // final_sample
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // silent, peak_level, peak_index, attack_length, tail_length, overflowed, pad
   output logic [nta_pkg::OUT_W-1:0]      rsp_tdata,
   input  logic                           csr_we,
   input  logic [1:0]                     csr_index,
   input  logic [nta_pkg::CSR_W-1:0]      csr_wdata
);
   import nta_pkg::*;

   nta_cmd_type  cmd;
   nta_stat_type stat;

   nta_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   nta_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
